/* rtl/core/dsbd_pkg.sv */
// ----------------------------------------------------------------------------
// dsbd_pkg
// Shared types and constants for the DEFLATE stored-block decoder.
// ----------------------------------------------------------------------------
package dsbd_pkg;

  // Header is five bytes: flags, LEN lo/hi, NLEN lo/hi
  localparam int unsigned HDR_BYTES = 5;
  localparam int unsigned HC_W      = 3;

  // Sticky error codes
  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_TYPE = 2'd1,
    ERR_LEN  = 2'd2
  } err_t;

  // Stored block type code
  localparam logic [1:0] BTYPE_STORED = 2'd0;

  // Input register stage contents
  typedef struct packed {
    logic       valid;
    logic [7:0] in_byte;
  } stage_t;

  // One result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       payload_valid;
    logic       byte_taken;
    logic [1:0] error_code;
    logic       final_seen;
    logic       stream_done;
  } result_t;

endpackage

/* rtl/core/dsbd_in_if.sv */
// ----------------------------------------------------------------------------
// dsbd_in_if
// Compressed byte channel: valid/ready with one stream byte per item.
// ----------------------------------------------------------------------------
interface dsbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

/* rtl/core/dsbd_out_if.sv */
// ----------------------------------------------------------------------------
// dsbd_out_if
// Result channel: valid/ready with one decode result per item.
// ----------------------------------------------------------------------------
interface dsbd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       payload_valid;
  logic       byte_taken;
  logic [1:0] error_code;
  logic       final_seen;
  logic       stream_done;

  modport source (output valid, output out_byte, output payload_valid,
                  output byte_taken, output error_code, output final_seen,
                  output stream_done, input ready);
  modport sink   (input valid, input out_byte, input payload_valid,
                  input byte_taken, input error_code, input final_seen,
                  input stream_done, output ready);
endinterface

/* rtl/core/dsbd_in_reg.sv */
// ----------------------------------------------------------------------------
// dsbd_in_reg
// Input register stage. Holds one accepted byte until the parser consumes it.
// ----------------------------------------------------------------------------
module dsbd_in_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [7:0]      in_byte,
  output logic            in_ready,
  input  logic            advance,
  output dsbd_pkg::stage_t stage
);
  import dsbd_pkg::*;

  logic       stage_valid;
  logic [7:0] stage_byte;

  // Free slot, or the held item leaves this cycle
  assign in_ready = !stage_valid || advance;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_byte <= in_byte;
    end
  end

  assign stage = '{valid: stage_valid, in_byte: stage_byte};

endmodule

/* rtl/core/dsbd_parser.sv */
// ----------------------------------------------------------------------------
// dsbd_parser
// Header/payload state and per-byte decode. One byte is processed per step.
// ----------------------------------------------------------------------------
module dsbd_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       in_byte,
  output dsbd_pkg::result_t res
);
  import dsbd_pkg::*;

  localparam logic [HC_W-1:0] HC_LAST = HC_W'(HDR_BYTES - 1);
  localparam logic [HC_W-1:0] HC_FULL = HC_W'(HDR_BYTES);

  // Header bytes 0..3; byte 4 is used straight from the input
  logic [7:0]      header_store [HDR_BYTES-1];
  logic [HC_W-1:0] header_count,  header_count_next;
  logic [15:0]     block_length,  block_length_next;
  logic [15:0]     bytes_copied,  bytes_copied_next;
  logic            in_payload,    in_payload_next;
  logic            final_flag,    final_flag_next;
  err_t            error_state,   error_state_next;

  logic            done_now;
  logic            active;
  logic            hdr_write;
  logic [15:0]     hdr_len;
  logic [15:0]     hdr_nlen;
  logic [15:0]     copied_inc;

  assign done_now   = final_flag && !in_payload && (header_count == '0) &&
                      (error_state == ERR_NONE);
  assign active     = (error_state == ERR_NONE) && !done_now;
  assign hdr_len    = {header_store[2], header_store[1]};
  assign hdr_nlen   = {in_byte, header_store[3]};
  assign copied_inc = bytes_copied + 16'd1;
  assign hdr_write  = step && active && !in_payload && (header_count != HC_LAST);

  // Next state
  always_comb begin
    header_count_next = header_count;
    block_length_next = block_length;
    bytes_copied_next = bytes_copied;
    in_payload_next   = in_payload;
    final_flag_next   = final_flag;
    error_state_next  = error_state;
    if (active) begin
      if (in_payload) begin
        bytes_copied_next = copied_inc;
        if (copied_inc == block_length) begin
          in_payload_next   = 1'b0;
          header_count_next = '0;
        end
      end else if (header_count != HC_LAST) begin
        header_count_next = header_count + HC_W'(1);
      end else begin
        // Last header byte: check the header in the same step
        header_count_next = HC_FULL;
        final_flag_next   = header_store[0][0];
        if (header_store[0][2:1] != BTYPE_STORED) begin
          error_state_next = ERR_TYPE;
        end else if (hdr_nlen != ~hdr_len) begin
          error_state_next = ERR_LEN;
        end else begin
          block_length_next = hdr_len;
          bytes_copied_next = '0;
          if (hdr_len == '0) begin
            header_count_next = '0;
            in_payload_next   = 1'b0;
          end else begin
            in_payload_next   = 1'b1;
          end
        end
      end
    end
  end

  // Result for this byte, status taken after the update
  always_comb begin
    res.out_byte      = (active && in_payload) ? in_byte : 8'd0;
    res.payload_valid = active && in_payload;
    res.byte_taken    = active;
    res.error_code    = error_state_next;
    res.final_seen    = final_flag_next;
    res.stream_done   = final_flag_next && !in_payload_next &&
                        (header_count_next == '0) && (error_state_next == ERR_NONE);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      header_count <= '0;
      block_length <= '0;
      bytes_copied <= '0;
      in_payload   <= 1'b0;
      final_flag   <= 1'b0;
      error_state  <= ERR_NONE;
    end else if (step) begin
      header_count <= header_count_next;
      block_length <= block_length_next;
      bytes_copied <= bytes_copied_next;
      in_payload   <= in_payload_next;
      final_flag   <= final_flag_next;
      error_state  <= error_state_next;
    end
  end

  // Header byte store, written at the current header position
  always_ff @(posedge clk) begin
    if (hdr_write) begin
      header_store[header_count[1:0]] <= in_byte;
    end
  end

endmodule

/* rtl/core/dsbd_out_reg.sv */
// ----------------------------------------------------------------------------
// dsbd_out_reg
// Result register. Loads when empty or when the held result is taken.
// ----------------------------------------------------------------------------
module dsbd_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load_valid,
  input  dsbd_pkg::result_t load_res,
  output logic              can_load,
  output logic              out_valid,
  input  logic              out_ready,
  output dsbd_pkg::result_t out_res
);
  import dsbd_pkg::*;

  assign can_load = !out_valid || out_ready;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load_valid;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (can_load && load_valid) begin
      out_res <= load_res;
    end
  end

endmodule

/* rtl/core/deflate_stored_block_decoder.sv */
// ----------------------------------------------------------------------------
// deflate_stored_block_decoder
// Decodes DEFLATE stored blocks from a byte stream, one byte per item.
// ----------------------------------------------------------------------------
// Channels: stream (sink) brings one compressed byte per item; result
// (source) gives exactly one result item per input byte, in order.
// A payload byte comes out with payload_valid high; header bytes, and bytes
// that arrive after the final block or after an error, give a result with
// payload_valid low (byte_taken low for the ignored ones). error_code,
// final_seen and stream_done show the status after that byte.
// Path: an accepted byte is registered in the input register, then decoded
// into the result register once that register can load, shown from then on.
// Throughput: one item per cycle unless result.ready stalls; the decode is a
// counter update and a 16-bit compare between input and result registers.
// stream.ready depends combinationally on result.ready through both stages.
// Stall: while result.ready is low the result holds, the input register
// keeps one more byte, and then stream.ready drops.
// Reset (rst, synchronous): both stages empty, no error, no header gathered.
// ----------------------------------------------------------------------------
module deflate_stored_block_decoder (
  input  logic       clk,
  input  logic       rst,
  dsbd_in_if.sink    stream,
  dsbd_out_if.source result
);
  import dsbd_pkg::*;

  stage_t  stage;
  result_t dec_res;
  result_t out_res;
  logic    can_load;
  logic    advance;

  // Held byte moves into the result register
  assign advance = stage.valid && can_load;

  dsbd_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (stream.valid),
    .in_byte  (stream.in_byte),
    .in_ready (stream.ready),
    .advance  (advance),
    .stage    (stage)
  );

  dsbd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .in_byte (stage.in_byte),
    .res     (dec_res)
  );

  dsbd_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load_valid (stage.valid),
    .load_res   (dec_res),
    .can_load   (can_load),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .out_res    (out_res)
  );

  // Result fields onto the channel
  assign result.out_byte      = out_res.out_byte;
  assign result.payload_valid = out_res.payload_valid;
  assign result.byte_taken    = out_res.byte_taken;
  assign result.error_code    = out_res.error_code;
  assign result.final_seen    = out_res.final_seen;
  assign result.stream_done   = out_res.stream_done;

endmodule

/* rtl/core/dsbd_checker.sv */
// ----------------------------------------------------------------------------
// dsbd_checker
// Port-level assertions for the stored-block decoder, bound to the top level.
// ----------------------------------------------------------------------------
module dsbd_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic [7:0] out_byte,
  input logic       payload_valid,
  input logic       byte_taken,
  input logic [1:0] error_code,
  input logic       final_seen,
  input logic       stream_done
);
  import dsbd_pkg::*;

  logic       res_fire;
  logic [1:0] last_err;

  assign res_fire = res_valid && res_ready;

  // Error code of the last delivered result
  always_ff @(posedge clk) begin
    if (rst) begin
      last_err <= ERR_NONE;
    end else if (res_fire) begin
      last_err <= error_code;
    end
  end

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(out_byte) &&
      $stable(payload_valid) && $stable(error_code) && $stable(stream_done))
    else $error("result changed while stalled");

  // Errors are sticky across items
  a_sticky: assert property (@(posedge clk) disable iff (rst)
    res_valid && (last_err != ERR_NONE) |-> error_code == last_err)
    else $error("error code not sticky");

  // Payload only while consuming and error free
  a_payload: assert property (@(posedge clk) disable iff (rst)
    res_valid && payload_valid |-> byte_taken && (error_code == ERR_NONE))
    else $error("payload with error or untaken byte");

  // Done implies a final header and no error; the last payload byte may carry it
  a_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && stream_done |-> final_seen && (error_code == ERR_NONE))
    else $error("stream done without final block");

endmodule

bind deflate_stored_block_decoder dsbd_checker u_dsbd_checker (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (result.valid),
  .res_ready     (result.ready),
  .out_byte      (result.out_byte),
  .payload_valid (result.payload_valid),
  .byte_taken    (result.byte_taken),
  .error_code    (result.error_code),
  .final_seen    (result.final_seen),
  .stream_done   (result.stream_done)
);

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Checks the stored-block decoder byte by byte against a local model of the
// decode. It starts with a short table of header and payload bytes, then
// sends random well-formed non-final blocks. The stream is closed by one
// randomly picked ending: a final block, an empty final block, a bad block
// type or a bad length check. Trailing bytes confirm that the block ignores
// input after that point. Both channels idle at random, and one long result
// stall is used to back up the input side.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dsbd_pkg::*;

  localparam int TIMEOUT_CYCLES = 300000;
  localparam int RANDOM_ITEMS   = 700;
  localparam int HOLD_CYCLES    = 48;

  // How the random stream is closed
  typedef enum int {
    END_FINAL,
    END_EMPTY_FINAL,
    END_BAD_TYPE,
    END_BAD_LEN
  } stream_end_t;

  // One row of the directed table; exp is used only when has_exp is set
  typedef struct packed {
    logic [7:0] b;
    logic       has_exp;
    result_t    exp;
  } dir_row_t;

  localparam result_t HDR_OK = '{8'h00, 1'b0, 1'b1, ERR_NONE, 1'b0, 1'b0};

  localparam dir_row_t DIR_ROWS [20] = '{
    // non-final stored block, ignored flag bits all set, LEN 0
    '{8'hF8, 1'b1, HDR_OK},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'hFF, 1'b1, HDR_OK},
    // LEN 3 with payload extremes
    '{8'h00, 1'b0, '0},
    '{8'h03, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'hFC, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'h00, 1'b1, '{8'h00, 1'b1, 1'b1, ERR_NONE, 1'b0, 1'b0}},
    '{8'hFF, 1'b1, '{8'hFF, 1'b1, 1'b1, ERR_NONE, 1'b0, 1'b0}},
    '{8'hA5, 1'b0, '0},
    // LEN 1
    '{8'h00, 1'b0, '0},
    '{8'h01, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'hFE, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'h5A, 1'b0, '0},
    // header byte with only odd ignored bits set
    '{8'hA8, 1'b0, '0}
  };

  logic clk;
  logic rst;

  dsbd_in_if  stream ();
  dsbd_out_if result ();

  deflate_stored_block_decoder DUT (
    .clk    (clk),
    .rst    (rst),
    .stream (stream),
    .result (result)
  );

  // Decoder state mirror
  logic [7:0]  hdr_bytes [HDR_BYTES];
  logic [2:0]  hdr_cnt;
  logic [15:0] blk_len;
  logic [15:0] copied;
  logic        payload_on;
  logic        final_f;
  err_t        err_st;

  result_t decoded_q [$];

  int  n_fail;
  int  n_sent;
  int  cycles;
  bit  idle_on;
  int  hold_asked;
  int  hold_served;
  int  hold_left;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit stream_ended();
    return final_f && !payload_on && hdr_cnt == 0 && err_st == ERR_NONE;
  endfunction

  // Advance the mirror by one accepted byte and return its result item
  function automatic result_t decode_byte(input logic [7:0] b);
    result_t     r;
    logic [15:0] len;
    logic [15:0] nlen;
    r = '0;
    if (err_st == ERR_NONE && !stream_ended()) begin
      r.byte_taken = 1'b1;
      if (payload_on) begin
        r.out_byte      = b;
        r.payload_valid = 1'b1;
        copied          = copied + 16'd1;
        if (copied == blk_len) begin
          payload_on = 1'b0;
          hdr_cnt    = '0;
        end
      end else begin
        if (hdr_cnt < HDR_BYTES) begin
          hdr_bytes[hdr_cnt] = b;
          hdr_cnt            = hdr_cnt + 3'd1;
        end
        // header complete: check type first, then LEN/NLEN
        if (hdr_cnt >= HDR_BYTES) begin
          len     = {hdr_bytes[2], hdr_bytes[1]};
          nlen    = {hdr_bytes[4], hdr_bytes[3]};
          final_f = hdr_bytes[0][0];
          if (hdr_bytes[0][2:1] != BTYPE_STORED) begin
            err_st = ERR_TYPE;
          end else if (nlen != ~len) begin
            err_st = ERR_LEN;
          end else begin
            blk_len = len;
            copied  = '0;
            if (len == 16'd0) begin
              hdr_cnt    = '0;
              payload_on = 1'b0;
            end else begin
              payload_on = 1'b1;
            end
          end
        end
      end
    end
    r.error_code  = err_st;
    r.final_seen  = final_f;
    r.stream_done = stream_ended();
    return r;
  endfunction

  task automatic report(input string msg);
    $display("MISMATCH @%0d: %s", cycles, msg);
    n_fail++;
  endtask

  task automatic check_result(input result_t got, input result_t want);
    if (got.out_byte !== want.out_byte)
      report($sformatf("out_byte got %h want %h", got.out_byte, want.out_byte));
    if (got.payload_valid !== want.payload_valid)
      report($sformatf("payload_valid got %b want %b", got.payload_valid,
                       want.payload_valid));
    if (got.byte_taken !== want.byte_taken)
      report($sformatf("byte_taken got %b want %b", got.byte_taken, want.byte_taken));
    if (got.error_code !== want.error_code)
      report($sformatf("error_code got %0d want %0d", got.error_code, want.error_code));
    if (got.final_seen !== want.final_seen)
      report($sformatf("final_seen got %b want %b", got.final_seen, want.final_seen));
    if (got.stream_done !== want.stream_done)
      report($sformatf("stream_done got %b want %b", got.stream_done, want.stream_done));
  endtask

  // Offer one byte from a falling edge; on acceptance queue its expected item
  task automatic send_byte(input logic [7:0] b, input bit has_exp, input result_t exp);
    result_t r;
    while (idle_on && $urandom_range(0, 99) < 27) begin
      stream.valid <= 1'b0;
      @(negedge clk);
    end
    stream.valid   <= 1'b1;
    stream.in_byte <= b;
    do @(posedge clk); while (stream.ready !== 1'b1);
    r = decode_byte(b);
    decoded_q.push_back(has_exp ? exp : r);
    n_sent++;
    @(negedge clk);
  endtask

  // Five header bytes, then the payload if the header is good
  task automatic send_block(input bit fin, input logic [1:0] btype,
                            input logic [15:0] len, input bit bad_len);
    logic [15:0] nlen;
    logic [4:0]  pad;
    nlen = ~len;
    if (bad_len)
      nlen = nlen ^ (16'h1 << $urandom_range(0, 15));
    pad = 5'($urandom);
    send_byte({pad, btype, fin}, 1'b0, '0);
    send_byte(len[7:0], 1'b0, '0);
    send_byte(len[15:8], 1'b0, '0);
    send_byte(nlen[7:0], 1'b0, '0);
    send_byte(nlen[15:8], 1'b0, '0);
    if (btype == BTYPE_STORED && !bad_len)
      repeat (len) send_byte(8'($urandom), 1'b0, '0);
  endtask

  // Wait with the input idle until every queued result has come back
  task automatic drain();
    stream.valid <= 1'b0;
    while (decoded_q.size() != 0) @(negedge clk);
  endtask

  // Result side: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else if (hold_left != 0) begin
      result.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_served != hold_asked) begin
      result.ready <= 1'b0;
      hold_served  <= hold_asked;
      hold_left    <= HOLD_CYCLES - 1;
    end else begin
      result.ready <= !(idle_on && $urandom_range(0, 99) < 27);
    end
  end

  // Result checking and run limit
  always @(posedge clk) begin : mon
    result_t got;
    cycles++;
    if (cycles > TIMEOUT_CYCLES) begin
      $display("TIMEOUT after %0d cycles, %0d items outstanding", cycles,
               decoded_q.size());
      $display("Test completed with failures");
      $finish;
    end else if (!rst && result.valid === 1'b1 && result.ready === 1'b1) begin
      got = '{result.out_byte, result.payload_valid, result.byte_taken,
              result.error_code, result.final_seen, result.stream_done};
      if (decoded_q.size() == 0)
        report($sformatf("unexpected result item, out_byte %h", got.out_byte));
      else
        check_result(got, decoded_q.pop_front());
    end
  end

  // Stimulus
  initial begin
    logic [15:0] len;
    bit          first;
    clk            = 1'b0;
    rst            = 1'b1;
    stream.valid   = 1'b0;
    stream.in_byte = 8'h00;
    result.ready   = 1'b0;
    n_fail         = 0;
    n_sent         = 0;
    cycles         = 0;
    idle_on        = 1'b1;
    hold_asked     = 0;
    hold_served    = 0;
    hold_left      = 0;
    hdr_cnt        = '0;
    blk_len        = '0;
    copied         = '0;
    payload_on     = 1'b0;
    final_f        = 1'b0;
    err_st         = ERR_NONE;
    foreach (hdr_bytes[i]) hdr_bytes[i] = '0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table
    foreach (DIR_ROWS[i])
      send_byte(DIR_ROWS[i].b, DIR_ROWS[i].has_exp, DIR_ROWS[i].exp);
    // finish the header opened by the last row: LEN 2
    send_byte(8'h02, 1'b0, '0);
    send_byte(8'h00, 1'b0, '0);
    send_byte(8'hFD, 1'b0, '0);
    send_byte(8'hFF, 1'b0, '0);
    send_byte(8'h00, 1'b0, '0);
    send_byte(8'hFF, 1'b0, '0);

    // Long result stall while the input keeps coming
    hold_asked++;
    first = 1'b1;

    // Random well-formed non-final blocks
    while (n_sent < RANDOM_ITEMS) begin
      idle_on = !(n_sent >= 300 && n_sent < 450);
      if (first)
        len = 16'($urandom_range(256, 511));
      else if ($urandom_range(0, 3) != 0)
        len = 16'($urandom_range(0, 12));
      else
        len = 16'($urandom_range(13, 60));
      first = 1'b0;
      send_block(1'b0, BTYPE_STORED, len, 1'b0);
      if (n_sent >= 500 && n_sent < 560)
        drain();
    end
    idle_on = 1'b1;
    drain();

    // One closing event per run, then bytes that must be ignored
    case (stream_end_t'($urandom_range(0, 3)))
      END_FINAL:       send_block(1'b1, BTYPE_STORED, 16'($urandom_range(1, 20)), 1'b0);
      END_EMPTY_FINAL: send_block(1'b1, BTYPE_STORED, 16'd0, 1'b0);
      END_BAD_TYPE:    send_block(1'($urandom), 2'($urandom_range(1, 3)),
                                  16'($urandom_range(0, 20)), 1'($urandom));
      default:         send_block(1'($urandom), BTYPE_STORED, 16'($urandom), 1'b1);
    endcase
    repeat (12) send_byte(8'($urandom), 1'b0, '0);
    stream.valid <= 1'b0;

    while (decoded_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (n_fail == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
